// ===== sv/mi3_pkg.sv =====
// Shared types and constants for the 3x3 matrix inverse block.
// No dependencies.
package mi3_pkg;
   localparam int EW = 32;
   localparam int CW = 65;
   localparam int DW = 99;
   localparam int QW = 32;
   localparam int DIV_LAT = QW + 2;

   typedef logic signed [EW-1:0] elem_type;
   typedef logic signed [CW-1:0] cof_type;
   typedef logic signed [DW-1:0] det_type;
   typedef logic signed [2*EW-1:0] prod_type;

   localparam elem_type ONE = elem_type'(1);

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_SINGULAR = 2'd1,
      ST_SAT      = 2'd2
   } status_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] dim;
      logic       singular;
   } ctl_type;
endpackage

// ===== sv/matrix_inverse_3x3.sv =====
// Matrix inverse top level: register, cofactor lanes, determinant merge, divider lanes.
// Depends on mi3_pkg, mi3_cofactor, mi3_det, mi3_div_lane.
//
// Usage:
//   Input transaction: req_a00..req_a22, one whole matrix, signed Q16.16, on
//   req_valid/req_ready. Result transaction: rsp_b00..rsp_b22 and rsp_status
//   on rsp_valid/rsp_ready. The active size (1..3) is written through
//   csr_wr_en/csr_wr_data while no transaction is in flight; 0 acts as 1.
//   From accept to rsp_valid a matrix passes two cofactor stages, two
//   determinant stages, one magnitude stage, and 34 divider stages (one
//   quotient bit per stage plus entry and exit stages).
//   Throughput is one matrix per cycle while results are taken; nine divider lanes run side by side.
//   When the receiver stalls with a result held, the whole pipeline holds and
//   req_ready drops in the same cycle; it rises again once the result is taken.
//   Reset empties the pipeline and sets the size to 3.
//   Status: 0 ok, 1 singular (all outputs zero), 2 some element saturated.
module matrix_inverse_3x3 #(
   parameter int FRAC_BITS = 16,
   parameter int MAX_DIM   = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mi3_pkg::elem_type req_a00,
   input  mi3_pkg::elem_type req_a01,
   input  mi3_pkg::elem_type req_a02,
   input  mi3_pkg::elem_type req_a10,
   input  mi3_pkg::elem_type req_a11,
   input  mi3_pkg::elem_type req_a12,
   input  mi3_pkg::elem_type req_a20,
   input  mi3_pkg::elem_type req_a21,
   input  mi3_pkg::elem_type req_a22,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mi3_pkg::elem_type rsp_b00,
   output mi3_pkg::elem_type rsp_b01,
   output mi3_pkg::elem_type rsp_b02,
   output mi3_pkg::elem_type rsp_b10,
   output mi3_pkg::elem_type rsp_b11,
   output mi3_pkg::elem_type rsp_b12,
   output mi3_pkg::elem_type rsp_b20,
   output mi3_pkg::elem_type rsp_b21,
   output mi3_pkg::elem_type rsp_b22,
   output logic [1:0]        rsp_status,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_wr_data
);
   import mi3_pkg::*;

   localparam int NUM_W = CW - 1 + 2 * FRAC_BITS;

   logic       adv;
   logic [1:0] size_ff, dim;
   ctl_type    ctl_in, cof_ctl, det_ctl, prep_ctl_ff, last;
   ctl_type    div_ctl_ff [DIV_LAT];
   elem_type   a [9];
   elem_type   row0 [3];
   cof_type    cof_w [9];
   cof_type    cof_d [9];
   det_type    det_w, det_abs;
   logic [NUM_W-1:0] nmag_ff [9];
   logic [DW-1:0]    dmag_ff;
   logic             neg_ff [9];
   elem_type   q_w [9];
   elem_type   b_w [9];
   logic [8:0] sat_w, act;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= 2'd3;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   assign dim = (size_ff == 2'd0) ? 2'd1 : ((size_ff > 2'(MAX_DIM)) ? 2'(MAX_DIM) : size_ff);
   assign adv = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign ctl_in = '{valid: req_valid, dim: dim, singular: 1'b0};

   assign a = '{req_a00, req_a01, req_a02, req_a10, req_a11, req_a12,
                req_a20, req_a21, req_a22};

   mi3_cofactor u_cof (
      .clock(clock), .reset(reset), .adv(adv), .ctl_in(ctl_in), .a(a),
      .ctl_out(cof_ctl), .row0_out(row0), .cof_out(cof_w)
   );

   mi3_det u_det (
      .clock(clock), .reset(reset), .adv(adv), .ctl_in(cof_ctl), .row0(row0),
      .cof_in(cof_w), .ctl_out(det_ctl), .cof_out(cof_d), .det_out(det_w)
   );

   assign det_abs = det_w[DW-1] ? -det_w : det_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ctl_ff <= '0;
         for (int k = 0; k < DIV_LAT; k++) begin
            div_ctl_ff[k] <= '0;
         end
      end else if (adv) begin
         prep_ctl_ff <= '{valid: det_ctl.valid, dim: det_ctl.dim, singular: (det_w == '0)};
         div_ctl_ff[0] <= prep_ctl_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            div_ctl_ff[k] <= div_ctl_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dmag_ff <= det_abs;
      end
   end

   assign last = div_ctl_ff[DIV_LAT-1];

   for (genvar r = 0; r < 3; r++) begin : g_r
      for (genvar c = 0; c < 3; c++) begin : g_c
         localparam int L = r * 3 + c;
         localparam int S = c * 3 + r;
         cof_type cabs;

         assign cabs = cof_d[S][CW-1] ? -cof_d[S] : cof_d[S];

         always_ff @(posedge clock) begin
            if (adv) begin
               nmag_ff[L] <= NUM_W'(cabs[CW-2:0]) << (2 * FRAC_BITS);
               neg_ff[L]  <= cof_d[S][CW-1] ^ det_w[DW-1];
            end
         end

         mi3_div_lane #(.NUM_W(NUM_W), .DEN_W(DW)) u_lane (
            .clock(clock), .adv(adv), .num(nmag_ff[L]), .den(dmag_ff),
            .neg(neg_ff[L]), .quot(q_w[L]), .sat(sat_w[L])
         );

         assign act[L] = (2'(r) < last.dim) && (2'(c) < last.dim);
         assign b_w[L] = (last.singular || !act[L]) ? '0 : q_w[L];
      end
   end

   assign rsp_valid  = last.valid;
   assign rsp_status = last.singular ? ST_SINGULAR : (|(sat_w & act) ? ST_SAT : ST_OK);
   assign rsp_b00 = b_w[0];
   assign rsp_b01 = b_w[1];
   assign rsp_b02 = b_w[2];
   assign rsp_b10 = b_w[3];
   assign rsp_b11 = b_w[4];
   assign rsp_b12 = b_w[5];
   assign rsp_b20 = b_w[6];
   assign rsp_b21 = b_w[7];
   assign rsp_b22 = b_w[8];
endmodule

// ===== sv/mi3_cofactor.sv =====
// Nine cofactor lanes: two 32x32 products per lane, then the signed difference.
// Depends on mi3_pkg.
module mi3_cofactor (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  mi3_pkg::ctl_type  ctl_in,
   input  mi3_pkg::elem_type a [9],
   output mi3_pkg::ctl_type  ctl_out,
   output mi3_pkg::elem_type row0_out [3],
   output mi3_pkg::cof_type  cof_out [9]
);
   import mi3_pkg::*;

   ctl_type  ctl1_ff, ctl2_ff;
   elem_type row1_ff [3];
   elem_type row2_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else if (adv) begin
         ctl1_ff <= ctl_in;
         ctl2_ff <= ctl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            row1_ff[k] <= a[k];
            row2_ff[k] <= row1_ff[k];
         end
      end
   end

   assign ctl_out  = ctl2_ff;
   assign row0_out = row2_ff;

   for (genvar gi = 0; gi < 3; gi++) begin : g_row
      for (genvar gj = 0; gj < 3; gj++) begin : g_col
         localparam int R0 = (gi == 0) ? 1 : 0;
         localparam int R1 = (gi == 2) ? 1 : 2;
         localparam int C0 = (gj == 0) ? 1 : 0;
         localparam int C1 = (gj == 2) ? 1 : 2;
         localparam bit IN2 = (gi < 2) && (gj < 2);
         localparam int M = IN2 ? (1 - gi) * 3 + (1 - gj) : 0;
         localparam bit NEG = ((gi + gj) % 2 == 1);

         elem_type x, y, u, v;
         prod_type p1_ff, p2_ff;
         cof_type  c_ff, diff;

         always_comb begin
            x = '0;
            y = '0;
            u = '0;
            v = '0;
            case (ctl_in.dim)
               2'd3: begin
                  x = a[R0*3+C0];
                  y = a[R1*3+C1];
                  u = a[R0*3+C1];
                  v = a[R1*3+C0];
               end
               2'd2: begin
                  if (IN2) begin
                     x = a[M];
                     y = ONE;
                  end
               end
               default: begin
                  if (gi == 0 && gj == 0) begin
                     x = ONE;
                     y = ONE;
                  end
               end
            endcase
         end

         assign diff = cof_type'(p1_ff) - cof_type'(p2_ff);

         always_ff @(posedge clock) begin
            if (adv) begin
               p1_ff <= x * y;
               p2_ff <= u * v;
               c_ff  <= NEG ? -diff : diff;
            end
         end

         assign cof_out[gi*3+gj] = c_ff;
      end
   end
endmodule

// ===== sv/mi3_det.sv =====
// Merge stage: first-row expansion of the determinant from the cofactor lanes.
// Depends on mi3_pkg.
module mi3_det (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  mi3_pkg::ctl_type  ctl_in,
   input  mi3_pkg::elem_type row0 [3],
   input  mi3_pkg::cof_type  cof_in [9],
   output mi3_pkg::ctl_type  ctl_out,
   output mi3_pkg::cof_type  cof_out [9],
   output mi3_pkg::det_type  det_out
);
   import mi3_pkg::*;

   ctl_type ctl1_ff, ctl2_ff;
   cof_type c1_ff [9];
   cof_type c2_ff [9];
   logic signed [EW+CW-EW:0] plo_ff [3];
   logic signed [EW+CW-EW:0] phi_ff [3];
   det_type det_ff, det_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else if (adv) begin
         ctl1_ff <= ctl_in;
         ctl2_ff <= ctl1_ff;
      end
   end

   always_comb begin
      det_in = '0;
      for (int j = 0; j < 3; j++) begin
         det_in = det_in + det_type'(plo_ff[j]) + (det_type'(phi_ff[j]) <<< EW);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            plo_ff[j] <= row0[j] * $signed({1'b0, cof_in[j][EW-1:0]});
            phi_ff[j] <= row0[j] * $signed(cof_in[j][CW-1:EW]);
         end
         for (int k = 0; k < 9; k++) begin
            c1_ff[k] <= cof_in[k];
            c2_ff[k] <= c1_ff[k];
         end
         det_ff <= det_in;
      end
   end

   assign ctl_out = ctl2_ff;
   assign cof_out = c2_ff;
   assign det_out = det_ff;
endmodule

// ===== sv/mi3_div_lane.sv =====
// One pipelined restoring divider lane, one quotient bit per stage, with saturation.
// Depends on mi3_pkg.
module mi3_div_lane #(
   parameter int NUM_W = 96,
   parameter int DEN_W = 99
) (
   input  logic                    clock,
   input  logic                    adv,
   input  logic [NUM_W-1:0]        num,
   input  logic [DEN_W-1:0]        den,
   input  logic                    neg,
   output mi3_pkg::elem_type       quot,
   output logic                    sat
);
   import mi3_pkg::*;

   localparam int RW = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

   logic [NUM_W-1:0] r_ff   [QW+1];
   logic [DEN_W-1:0] d_ff   [QW+1];
   logic [QW-1:0]    q_ff   [QW+1];
   logic             neg_ff [QW+1];
   logic             big_ff [QW+1];
   logic [QW-1:0]    limit;
   logic             sat_in;
   elem_type         quot_ff;
   logic             sat_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff[0]   <= num;
         d_ff[0]   <= den;
         q_ff[0]   <= '0;
         neg_ff[0] <= neg;
         big_ff[0] <= RW'(num) >= (RW'(den) << QW);
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_bit
      localparam int B = QW - 1 - k;
      logic [RW-1:0] ds;
      logic          ge;

      assign ds = RW'(d_ff[k]) << B;
      assign ge = RW'(r_ff[k]) >= ds;

      always_ff @(posedge clock) begin
         if (adv) begin
            r_ff[k+1]   <= ge ? NUM_W'(RW'(r_ff[k]) - ds) : r_ff[k];
            q_ff[k+1]   <= q_ff[k] | (QW'(ge) << B);
            d_ff[k+1]   <= d_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            big_ff[k+1] <= big_ff[k];
         end
      end
   end

   assign limit  = neg_ff[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
   assign sat_in = big_ff[QW] || (q_ff[QW] > limit);

   always_ff @(posedge clock) begin
      if (adv) begin
         sat_ff  <= sat_in;
         quot_ff <= sat_in ? elem_type'(limit)
                    : (neg_ff[QW] ? elem_type'(-q_ff[QW]) : elem_type'(q_ff[QW]));
      end
   end

   assign quot = quot_ff;
   assign sat  = sat_ff;
endmodule

// ===== sv/mi3_checker.sv =====
// Port-level checks for matrix_inverse_3x3, attached by bind.
// Depends on mi3_pkg and matrix_inverse_3x3.
module mi3_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mi3_pkg::elem_type rsp_b00,
   input mi3_pkg::elem_type rsp_b11,
   input mi3_pkg::elem_type rsp_b22,
   input logic [1:0]        rsp_status
);
   import mi3_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_b00) && $stable(rsp_status))
      else $error("stalled result changed");

   a_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result stalled");

   a_sing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_SINGULAR |-> rsp_b00 == '0 && rsp_b11 == '0 && rsp_b22 == '0)
      else $error("singular result not zero");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready), .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready), .rsp_b00(rsp_b00), .rsp_b11(rsp_b11), .rsp_b22(rsp_b22),
   .rsp_status(rsp_status)
);

// ===== test/matrix_inverse_3x3_test.sv =====
// Testbench for matrix_inverse_3x3: directed and random matrices at every active size.
// Depends on mi3_pkg and the matrix_inverse_3x3 RTL; the inverse is predicted with
// exact wide integer arithmetic.
`timescale 1ns / 1ps

module matrix_inverse_3x3_test;
   import mi3_pkg::*;

   typedef logic [8:0][31:0] mat_type;
   typedef logic signed [199:0] wide_type;

   class inverse_scoreboard;
      typedef struct packed {
         mat_type    b;
         status_type st;
      } inverse_type;

      inverse_type pending[$];
      int          size = 3;
      int          errors = 0;

      function void note(mat_type a);
         wide_type    x[3][3];
         wide_type    adj[3][3];
         wide_type    det;
         wide_type    q;
         inverse_type r;
         int          n;
         n = (size == 0) ? 1 : size;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               x[i][j] = wide_type'($signed(a[i*3+j]));
               adj[i][j] = '0;
            end
         end
         case (n)
            1: begin
               det = x[0][0];
               adj[0][0] = 1;
            end
            2: begin
               det = x[0][0] * x[1][1] - x[0][1] * x[1][0];
               adj[0][0] = x[1][1];
               adj[0][1] = -x[0][1];
               adj[1][0] = -x[1][0];
               adj[1][1] = x[0][0];
            end
            default: begin
               det = '0;
               for (int i = 0; i < 3; i++) begin
                  for (int j = 0; j < 3; j++) begin
                     adj[j][i] = x[(i+1)%3][(j+1)%3] * x[(i+2)%3][(j+2)%3]
                               - x[(i+1)%3][(j+2)%3] * x[(i+2)%3][(j+1)%3];
                  end
               end
               for (int j = 0; j < 3; j++) det = det + x[0][j] * adj[j][0];
            end
         endcase
         r.b = '0;
         r.st = ST_OK;
         if (det == 0) begin
            r.st = ST_SINGULAR;
         end else begin
            for (int i = 0; i < n; i++) begin
               for (int j = 0; j < n; j++) begin
                  q = (adj[i][j] <<< 32) / det;
                  if (q > 64'sd2147483647) begin
                     r.b[i*3+j] = 32'h7FFF_FFFF;
                     r.st = ST_SAT;
                  end else if (q < -64'sd2147483648) begin
                     r.b[i*3+j] = 32'h8000_0000;
                     r.st = ST_SAT;
                  end else begin
                     r.b[i*3+j] = q[31:0];
                  end
               end
            end
         end
         pending.push_back(r);
      endfunction

      function void check(mat_type b, logic [1:0] st);
         inverse_type e;
         if (pending.size() == 0) begin
            $error("unexpected result transaction");
            errors++;
            return;
         end
         e = pending.pop_front();
         for (int k = 0; k < 9; k++) begin
            if (b[k] !== e.b[k]) begin
               $error("b%0d%0d expected %h actual %h", k / 3, k % 3, e.b[k], b[k]);
               errors++;
            end
         end
         if (st !== e.st) begin
            $error("status expected %0d actual %0d", e.st, st);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   elem_type   req_a00 = '0, req_a01 = '0, req_a02 = '0;
   elem_type   req_a10 = '0, req_a11 = '0, req_a12 = '0;
   elem_type   req_a20 = '0, req_a21 = '0, req_a22 = '0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   elem_type   rsp_b00, rsp_b01, rsp_b02, rsp_b10, rsp_b11, rsp_b12;
   elem_type   rsp_b20, rsp_b21, rsp_b22;
   logic [1:0] rsp_status;
   logic       csr_wr_en = 0;
   logic [1:0] csr_wr_data = '0;

   inverse_scoreboard sb = new();
   bit quiet = 0;
   bit long_hold = 0;
   int idle_cycles = 0;
   localparam int WATCHDOG_LIMIT = 5000;

   matrix_inverse_3x3 dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_a00(req_a00), .req_a01(req_a01), .req_a02(req_a02),
      .req_a10(req_a10), .req_a11(req_a11), .req_a12(req_a12),
      .req_a20(req_a20), .req_a21(req_a21), .req_a22(req_a22),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_b00(rsp_b00), .rsp_b01(rsp_b01), .rsp_b02(rsp_b02),
      .rsp_b10(rsp_b10), .rsp_b11(rsp_b11), .rsp_b12(rsp_b12),
      .rsp_b20(rsp_b20), .rsp_b21(rsp_b21), .rsp_b22(rsp_b22),
      .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note({req_a22, req_a21, req_a20, req_a12, req_a11, req_a10,
                  req_a02, req_a01, req_a00});
      if (!reset && rsp_valid && rsp_ready)
         sb.check({rsp_b22, rsp_b21, rsp_b20, rsp_b12, rsp_b11, rsp_b10,
                   rsp_b02, rsp_b01, rsp_b00}, rsp_status);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ready <= 0;
            repeat (300) @(posedge clock);
            long_hold = 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   function automatic mat_type mat(int e0, int e1, int e2, int e3, int e4, int e5,
                                   int e6, int e7, int e8);
      return {e8, e7, e6, e5, e4, e3, e2, e1, e0};
   endfunction

   task automatic send(mat_type m);
      req_valid <= 1;
      {req_a22, req_a21, req_a20, req_a12, req_a11, req_a10, req_a02, req_a01, req_a00} <= m;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic set_size(int v);
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= v[1:0];
      @(posedge clock);
      sb.size = v & 3;
      csr_wr_en <= 0;
   endtask

   function automatic logic [31:0] rand_elem(int mode);
      logic [31:0] pick[6];
      pick = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h1_0000};
      case (mode)
         0, 1: return $urandom;
         7: return $urandom_range(0, 31) - 16;
         8: return pick[$urandom_range(0, 5)];
         default: return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
      endcase
   endfunction

   function automatic mat_type rand_mat();
      mat_type m;
      int mode;
      mode = $urandom_range(0, 9);
      for (int k = 0; k < 9; k++) m[k] = rand_elem(mode);
      if (mode == 6) begin
         if ($urandom_range(0, 1)) m[8:6] = m[2:0];
         else m[1] = 0;
         if ($urandom_range(0, 1)) begin
            m[3] = m[0];
            m[4] = m[1];
         end else begin
            m[3] = 0;
            m[0] = 0;
            m[6] = 0;
         end
      end
      if (mode == 9) m[$urandom_range(0, 8)] = $urandom;
      return m;
   endfunction

   initial begin
      int sizes[8];
      sizes = '{3, 1, 2, 0, 3, 2, 1, 3};
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send(mat(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000));
      send(mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send(mat(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
               32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
      send(mat(32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000));
      send(mat(32'h7FFFFFFF, 32'h80000000, 1, 32'h80000000, 32'h7FFFFFFF, -1,
               1, -1, 32'h80000000));
      send(mat(1, 0, 0, 0, 1, 0, 0, 0, 1));
      send(mat(0, 32'h10000, 0, 0, 0, 32'h10000, 32'h10000, 0, 0));
      send(mat(32'h20000, 32'h10000, 0, 32'h10000, 32'h30000, 32'h10000,
               0, 32'h10000, 32'h40000));
      send(mat(-1, 0, 0, 0, -1, 0, 0, 0, -1));

      for (int p = 1; p < 8; p++) begin
         set_size(sizes[p]);
         if (p == 1) begin
            send(mat(32'h10000, -7, 9, 3, 3, 3, 5, 5, 5));
            send(mat(32'h80000000, 1, 1, 1, 1, 1, 1, 1, 1));
            send(mat(32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0));
            send(mat(1, 0, 0, 0, 0, 0, 0, 0, 0));
            send(mat(-1, 0, 0, 0, 0, 0, 0, 0, 0));
            send(mat(0, 5, 5, 5, 5, 5, 5, 5, 5));
         end else if (p == 2) begin
            send(mat(32'h10000, 32'h20000, 9, 32'h30000, 32'h40000, 9, 9, 9, 0));
            send(mat(32'h10000, 32'h20000, 0, 32'h20000, 32'h40000, 0, 0, 0, 0));
            send(mat(1, 0, 7, 0, 1, 7, 7, 7, 7));
            send(mat(32'h80000000, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h80000000,
                     0, 0, 0, 0));
         end else if (p == 3) begin
            send(mat(32'h20000, 1, 1, 1, 1, 1, 1, 1, 1));
         end
         for (int i = 0; i < 160; i++) begin
            if (p == 4 && i == 40) long_hold = 1;
            if (p == 7 && i >= 60) quiet = 1;
            send(rand_mat());
         end
      end
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
